// ----- rtl/triangle_orientation_flagger_assert.svh -----
// Assertion macros for the orientation flagger.
`ifndef TRIANGLE_ORIENTATION_FLAGGER_ASSERT_SVH
`define TRIANGLE_ORIENTATION_FLAGGER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define TOF_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication.
`define TOF_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ----- rtl/tof_pkg.sv -----
`default_nettype none
package tof_pkg;
  typedef enum logic [2:0] {
    OP_WR_VTX = 3'd0,
    OP_WR_EDGE = 3'd1,
    OP_ANALYZE = 3'd2,
    OP_Q_VTX = 3'd3,
    OP_Q_EDGE = 3'd4,
    OP_CLEAR = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_REF,
    ST_REF_WAIT,
    ST_RD_CUR,
    ST_CUR_WAIT,
    ST_MUL,
    ST_DET,
    ST_VFLAG,
    ST_EDGE_WALK,
    ST_QUERY,
    ST_CLEAR,
    ST_OUT
  } state_t;

  localparam int unsigned REG_EDGE_COUNT = 0;
endpackage
`default_nettype wire

// ----- rtl/tof_if.sv -----
`default_nettype none
interface tof_in_if #(parameter int COORD_BITS = 16);
  logic valid;
  logic ready;
  logic [2:0] operation;
  logic [10:0] slot;
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [COORD_BITS-1:0] ref_x;
  logic signed [COORD_BITS-1:0] ref_y;
  logic [9:0] edge_end_a;
  logic [9:0] edge_end_b;
  logic [9:0] corner0;
  logic [9:0] corner1;
  logic [9:0] corner2;
  logic [15:0] triangle_id;
  modport source(output valid, operation, slot, cur_x, cur_y, ref_x, ref_y, edge_end_a,
    edge_end_b, corner0, corner1, corner2, triangle_id, input ready);
  modport sink(input valid, operation, slot, cur_x, cur_y, ref_x, ref_y, edge_end_a,
    edge_end_b, corner0, corner1, corner2, triangle_id, output ready);
endinterface

interface tof_out_if #(parameter int COORD_BITS = 16);
  logic valid;
  logic ready;
  logic [15:0] tri_tag;
  logic [9:0] base_vertex;
  logic [9:0] first_column_vertex;
  logic [9:0] second_column_vertex;
  logic signed [COORD_BITS:0] m00;
  logic signed [COORD_BITS:0] m10;
  logic signed [COORD_BITS:0] m01;
  logic signed [COORD_BITS:0] m11;
  logic signed [2*COORD_BITS+1:0] det_value;
  logic front_facing;
  logic flag_value;
  modport source(output valid, tri_tag, base_vertex, first_column_vertex,
    second_column_vertex, m00, m10, m01, m11, det_value, front_facing, flag_value,
    input ready);
  modport sink(input valid, tri_tag, base_vertex, first_column_vertex,
    second_column_vertex, m00, m10, m01, m11, det_value, front_facing, flag_value,
    output ready);
endinterface
`default_nettype wire

// ----- rtl/tof_ram.sv -----
`default_nettype none
module tof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/triangle_orientation_flagger.sv -----
// A non-positive triangle adds an edge walk over the first edge_count edge store entries
// (at most MAX_EDGES), one edge store entry a cycle; clear flags walks both flag stores.
// One item in flight; a result held by the sink stalls the next analyze or query.
// After reset a flag-clearing pass over both flag stores runs before any item.
// Reset clears control state and edge_count; vertex and edge stores undefined.
`default_nettype none
`include "triangle_orientation_flagger_assert.svh"
module triangle_orientation_flagger
  import tof_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES = 2048,
  parameter int COORD_BITS = 16
) (
  input wire logic clk,
  input wire logic rst,
  tof_in_if.sink in_ch,
  tof_out_if.source out_ch,
  input wire logic psel,
  input wire logic penable,
  input wire logic pwrite,
  input wire logic [1:0] paddr,
  input wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int VAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = 4 * COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int FAW = (VAW > EAW) ? VAW : EAW;

  state_t state, state_next;

  logic [11:0] edge_count;
  logic [2:0] op;
  logic [10:0] slot;
  logic [9:0] c0, c1, c2;
  logic [15:0] tag;
  logic [1:0] rd_idx;
  logic [CW-1:0] vdata [3];
  logic [EAW:0] ecnt;
  logic [FAW:0] clr_idx;
  logic [1:0] org;
  logic signed [DW-1:0] d00, d10, d01, d11;
  logic signed [PW-1:0] p0, p1, det;
  logic flag_q;
  logic pend_e;
  logic [EAW-1:0] pend_addr;
  logic [1:0] vf_idx;

  // vertex store
  logic v_we;
  logic [VAW-1:0] v_waddr, v_raddr;
  logic [CW-1:0] v_wdata, v_rdata;
  // edge store
  logic e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [19:0] e_wdata, e_rdata;
  // flag stores
  logic vf_we, vf_wd, vf_rd;
  logic [VAW-1:0] vf_waddr, vf_raddr;
  logic ef_we, ef_wd, ef_rd;
  logic [EAW-1:0] ef_waddr, ef_raddr;

  tof_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_vtx (.clk(clk), .we(v_we),
    .waddr(v_waddr), .wdata(v_wdata), .raddr(v_raddr), .rdata(v_rdata));
  tof_ram #(.WIDTH(20), .DEPTH(MAX_EDGES)) u_edge (.clk(clk), .we(e_we),
    .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata));
  tof_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_vflag (.clk(clk), .we(vf_we),
    .waddr(vf_waddr), .wdata(vf_wd), .raddr(vf_raddr), .rdata(vf_rd));
  tof_ram #(.WIDTH(1), .DEPTH(MAX_EDGES)) u_eflag (.clk(clk), .we(ef_we),
    .waddr(ef_waddr), .wdata(ef_wd), .raddr(ef_raddr), .rdata(ef_rd));

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr == 2'(REG_EDGE_COUNT)) ? {20'd0, edge_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
    end else if (psel && penable && pwrite && paddr == 2'(REG_EDGE_COUNT)) begin
      edge_count <= pwdata[11:0];
    end
  end

  logic in_fire;
  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;

  function automatic logic [9:0] corner_at(input logic [1:0] i, input logic [9:0] a,
                                           input logic [9:0] b, input logic [9:0] c);
    case (i)
      2'd0: corner_at = a;
      2'd1: corner_at = b;
      default: corner_at = c;
    endcase
  endfunction

  function automatic logic [1:0] wrap3(input logic [1:0] i);
    wrap3 = (i == 2'd2) ? 2'd0 : i + 2'd1;
  endfunction

  function automatic logic in_vrange(input logic [9:0] v);
    in_vrange = 32'(v) < MAX_VERTICES;
  endfunction

  // fields of a stored vertex (cur_x, cur_y, ref_x, ref_y packed high to low)
  logic signed [COORD_BITS-1:0] rx [3];
  logic signed [COORD_BITS-1:0] ry [3];
  logic signed [COORD_BITS-1:0] cx [3];
  logic signed [COORD_BITS-1:0] cy [3];
  logic signed [COORD_BITS:0] rs [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cx[i] = vdata[i][CW-1 -: COORD_BITS];
      cy[i] = vdata[i][CW-COORD_BITS-1 -: COORD_BITS];
      rx[i] = vdata[i][2*COORD_BITS-1 -: COORD_BITS];
      ry[i] = vdata[i][COORD_BITS-1:0];
      rs[i] = DW'(rx[i]) + DW'(ry[i]);
    end
  end

  function automatic logic lower(input logic signed [COORD_BITS:0] sa,
    input logic signed [COORD_BITS-1:0] ya, input logic signed [COORD_BITS-1:0] xa,
    input logic signed [COORD_BITS:0] sb, input logic signed [COORD_BITS-1:0] yb,
    input logic signed [COORD_BITS-1:0] xb);
    if (sa != sb) lower = sa < sb;
    else if (ya != yb) lower = ya < yb;
    else lower = xa < xb;
  endfunction

  logic [1:0] org_pick;
  logic [1:0] o1;
  always_comb begin
    o1 = lower(rs[1], ry[1], rx[1], rs[0], ry[0], rx[0]) ? 2'd1 : 2'd0;
    org_pick = lower(rs[2], ry[2], rx[2], rs[o1], ry[o1], rx[o1]) ? 2'd2 : o1;
  end

  logic [1:0] a_i, b_i;
  assign a_i = wrap3(org);
  assign b_i = wrap3(a_i);

  logic e_match;
  logic [9:0] ea, eb;
  always_comb begin
    ea = e_rdata[19:10];
    eb = e_rdata[9:0];
    e_match = (ea == c0 && eb == c1) || (ea == c1 && eb == c0) ||
              (ea == c1 && eb == c2) || (ea == c2 && eb == c1) ||
              (ea == c2 && eb == c0) || (ea == c0 && eb == c2);
  end

  logic [EAW:0] n_edges;
  assign n_edges = (32'(edge_count) < MAX_EDGES) ? (EAW+1)'(edge_count)
                                                 : (EAW+1)'(MAX_EDGES);
  logic [FAW:0] clr_len;
  assign clr_len = (MAX_VERTICES > MAX_EDGES) ? (FAW+1)'(MAX_VERTICES)
                                              : (FAW+1)'(MAX_EDGES);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_ch.operation)
            OP_ANALYZE: state_next = ST_RD_REF;
            OP_Q_VTX, OP_Q_EDGE: state_next = ST_QUERY;
            OP_CLEAR: state_next = ST_CLEAR;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD_REF: state_next = (rd_idx == 2'd2) ? ST_REF_WAIT : ST_RD_REF;
      ST_REF_WAIT: state_next = ST_RD_CUR;
      ST_RD_CUR: state_next = ST_CUR_WAIT;
      ST_CUR_WAIT: state_next = ST_MUL;
      ST_MUL: state_next = ST_DET;
      ST_DET: state_next = (det > 0) ? ST_OUT : ST_VFLAG;
      ST_VFLAG: state_next = (vf_idx == 2'd2) ? ST_EDGE_WALK : ST_VFLAG;
      ST_EDGE_WALK: state_next = (ecnt >= n_edges && !pend_e) ? ST_OUT : ST_EDGE_WALK;
      ST_QUERY: state_next = (flag_q) ? ST_OUT : ST_QUERY;
      ST_CLEAR: state_next = (clr_idx == clr_len - 1'b1) ? ST_IDLE : ST_CLEAR;
      ST_OUT: state_next = (!out_ch.valid || out_ch.ready) ? ST_IDLE : ST_OUT;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    v_we = in_fire && in_ch.operation == OP_WR_VTX && 32'(in_ch.slot) < MAX_VERTICES;
    v_waddr = VAW'(in_ch.slot);
    v_wdata = {in_ch.cur_x, in_ch.cur_y, in_ch.ref_x, in_ch.ref_y};
    v_raddr = VAW'(corner_at(rd_idx, c0, c1, c2));
    e_we = in_fire && in_ch.operation == OP_WR_EDGE && 32'(in_ch.slot) < MAX_EDGES;
    e_waddr = EAW'(in_ch.slot);
    e_wdata = {in_ch.edge_end_a, in_ch.edge_end_b};
    e_raddr = EAW'(ecnt);
    vf_we = 1'b0;
    vf_wd = 1'b1;
    vf_waddr = VAW'(corner_at(vf_idx, c0, c1, c2));
    vf_raddr = VAW'(slot);
    ef_we = pend_e && e_match;
    ef_wd = 1'b1;
    ef_waddr = pend_addr;
    ef_raddr = EAW'(slot);
    if (state == ST_VFLAG) vf_we = in_vrange(corner_at(vf_idx, c0, c1, c2));
    if (state == ST_CLEAR) begin
      vf_we = 32'(clr_idx) < MAX_VERTICES;
      vf_wd = 1'b0;
      vf_waddr = VAW'(clr_idx);
      ef_we = 32'(clr_idx) < MAX_EDGES;
      ef_wd = 1'b0;
      ef_waddr = EAW'(clr_idx);
    end
  end

  // vertex reads land in the cycle after the address; the last one is captured at the end
  // of ST_REF_WAIT, so the origin is picked in ST_RD_CUR
  logic rd_lat;
  logic [1:0] rd_lat_idx;
  logic signed [DW-1:0] ox, oy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
      rd_idx <= '0;
      vf_idx <= '0;
      ecnt <= '0;
      pend_e <= 1'b0;
      flag_q <= 1'b0;
      rd_lat <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_lat <= (state == ST_RD_REF);
      rd_lat_idx <= rd_idx;
      case (state)
        ST_IDLE: begin
          rd_idx <= '0;
          vf_idx <= '0;
          ecnt <= '0;
          clr_idx <= '0;
          flag_q <= 1'b0;
          pend_e <= 1'b0;
          if (in_fire) begin
            op <= in_ch.operation;
            slot <= in_ch.slot;
            c0 <= in_ch.corner0;
            c1 <= in_ch.corner1;
            c2 <= in_ch.corner2;
            tag <= in_ch.triangle_id;
          end
        end
        ST_RD_REF: rd_idx <= rd_idx + 2'd1;
        ST_REF_WAIT: ;
        ST_RD_CUR: org <= org_pick;
        ST_CUR_WAIT: begin
          // captured entries already hold the current positions
          ox <= DW'(cx[org]);
          oy <= DW'(cy[org]);
        end
        ST_MUL: begin
          p0 <= PW'(d00) * PW'(d11);
          p1 <= PW'(d01) * PW'(d10);
        end
        ST_DET: ;
        ST_VFLAG: vf_idx <= vf_idx + 2'd1;
        ST_EDGE_WALK: begin
          pend_e <= ecnt < n_edges;
          pend_addr <= EAW'(ecnt);
          if (ecnt < n_edges) ecnt <= ecnt + 1'b1;
        end
        ST_QUERY: flag_q <= 1'b1;
        ST_CLEAR: clr_idx <= clr_idx + 1'b1;
        default: ;
      endcase
      if (state == ST_OUT && (!out_ch.valid || out_ch.ready)) begin
        out_ch.valid <= 1'b1;
        if (op == OP_ANALYZE) begin
          out_ch.tri_tag <= tag;
          out_ch.base_vertex <= corner_at(org, c0, c1, c2);
          out_ch.first_column_vertex <= corner_at(a_i, c0, c1, c2);
          out_ch.second_column_vertex <= corner_at(b_i, c0, c1, c2);
          out_ch.m00 <= d00;
          out_ch.m10 <= d10;
          out_ch.m01 <= d01;
          out_ch.m11 <= d11;
          out_ch.det_value <= det;
          out_ch.front_facing <= det > 0;
          out_ch.flag_value <= 1'b0;
        end else begin
          out_ch.tri_tag <= '0;
          out_ch.base_vertex <= '0;
          out_ch.first_column_vertex <= '0;
          out_ch.second_column_vertex <= '0;
          out_ch.m00 <= '0;
          out_ch.m10 <= '0;
          out_ch.m01 <= '0;
          out_ch.m11 <= '0;
          out_ch.det_value <= '0;
          out_ch.front_facing <= 1'b0;
          out_ch.flag_value <= (op == OP_Q_VTX) ? (32'(slot) < MAX_VERTICES && vf_rd)
                                                : (32'(slot) < MAX_EDGES && ef_rd);
        end
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // vertex data capture; out-of-range corners read as zero
  always_ff @(posedge clk) begin
    if (rd_lat) begin
      vdata[rd_lat_idx] <= in_vrange(corner_at(rd_lat_idx, c0, c1, c2)) ? v_rdata : '0;
    end
  end

  // differences from the captured current positions of the column corners
  logic signed [COORD_BITS-1:0] ax_s, ay_s, bx_s, by_s;
  assign ax_s = cx[a_i];
  assign ay_s = cy[a_i];
  assign bx_s = cx[b_i];
  assign by_s = cy[b_i];
  assign d00 = DW'(ax_s) - ox;
  assign d10 = DW'(ay_s) - oy;
  assign d01 = DW'(bx_s) - ox;
  assign d11 = DW'(by_s) - oy;
  assign det = p0 - p1;

  `TOF_ASSERT_IMP(a_ready_idle, in_ch.ready, state == ST_IDLE)
  `TOF_ASSERT_NXT(a_out_after, state == ST_OUT && !out_ch.valid, out_ch.valid)
  `TOF_ASSERT_IMP(a_no_wr_busy, v_we || e_we, state == ST_IDLE)
  `TOF_ASSERT_IMP(a_walk_bound, state == ST_EDGE_WALK, ecnt <= n_edges)
endmodule
`default_nettype wire

// ----- tb/triangle_orientation_flagger_tb.sv -----
`timescale 1ns / 1ps
module triangle_orientation_flagger_tb;
  import tof_pkg::*;

  localparam int NUM_VTX = 1024;
  localparam int NUM_EDGE = 2048;
  localparam int RANDOM_ITEMS = 150;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [2:0] operation;
    logic [10:0] slot;
    logic signed [15:0] cur_x, cur_y, ref_x, ref_y;
    logic [9:0] edge_end_a, edge_end_b, corner0, corner1, corner2;
    logic [15:0] triangle_id;
  } item_t;

  typedef struct packed {
    logic [15:0] tri_tag;
    logic [9:0] base_vertex, first_column_vertex, second_column_vertex;
    logic signed [16:0] m00, m10, m01, m11;
    logic signed [33:0] det_value;
    logic front_facing;
    logic flag_value;
  } result_t;

  typedef struct {
    item_t it;
    logic has_exp;
    result_t exp_res;
  } row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  tof_in_if in_ch ();
  tof_out_if out_ch ();

  triangle_orientation_flagger dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic signed [15:0] vtx_cx[NUM_VTX], vtx_cy[NUM_VTX], vtx_rx[NUM_VTX], vtx_ry[NUM_VTX];
  logic [9:0] edge_a[NUM_EDGE], edge_b[NUM_EDGE];
  bit edge_written[NUM_EDGE];
  bit vtx_flag[NUM_VTX];
  bit edge_flag[NUM_EDGE];
  int unsigned edges_searched;

  result_t expected_results[$];
  int mismatches;
  bit quiet_tail;
  longint cycles;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic longint sum_xy(logic [9:0] v);
    return longint'(vtx_rx[v]) + longint'(vtx_ry[v]);
  endfunction

  function automatic bit more_lower_left(logic [9:0] c, logic [9:0] d);
    if (sum_xy(c) != sum_xy(d)) return sum_xy(c) < sum_xy(d);
    if (vtx_ry[c] != vtx_ry[d]) return vtx_ry[c] < vtx_ry[d];
    return vtx_rx[c] < vtx_rx[d];
  endfunction

  function automatic bit edge_joins(int e, logic [9:0] p, logic [9:0] q);
    return (edge_a[e] == p && edge_b[e] == q) || (edge_a[e] == q && edge_b[e] == p);
  endfunction

  // returns 1 when a result is produced
  function automatic bit predict_orientation(item_t it, output result_t r);
    logic [9:0] c[3];
    int o;
    int n;
    logic [9:0] vo, v1, v2;
    longint d00, d10, d01, d11, det;
    bit pos;
    r = '0;
    case (it.operation)
      OP_WR_VTX: begin
        if (it.slot < NUM_VTX) begin
          vtx_cx[it.slot] = it.cur_x; vtx_cy[it.slot] = it.cur_y;
          vtx_rx[it.slot] = it.ref_x; vtx_ry[it.slot] = it.ref_y;
        end
        return 0;
      end
      OP_WR_EDGE: begin
        edge_a[it.slot] = it.edge_end_a;
        edge_b[it.slot] = it.edge_end_b;
        edge_written[it.slot] = 1;
        return 0;
      end
      OP_CLEAR: begin
        foreach (vtx_flag[i]) vtx_flag[i] = 0;
        foreach (edge_flag[i]) edge_flag[i] = 0;
        return 0;
      end
      OP_Q_VTX: begin
        r.flag_value = (it.slot < NUM_VTX) ? vtx_flag[it.slot] : 1'b0;
        return 1;
      end
      OP_Q_EDGE: begin
        r.flag_value = edge_flag[it.slot];
        return 1;
      end
      OP_ANALYZE: begin
        c[0] = it.corner0; c[1] = it.corner1; c[2] = it.corner2;
        o = 0;
        for (int s = 1; s < 3; s++)
          if (more_lower_left(c[s], c[o])) o = s;
        vo = c[o]; v1 = c[(o + 1) % 3]; v2 = c[(o + 2) % 3];
        d00 = longint'(vtx_cx[v1]) - longint'(vtx_cx[vo]);
        d10 = longint'(vtx_cy[v1]) - longint'(vtx_cy[vo]);
        d01 = longint'(vtx_cx[v2]) - longint'(vtx_cx[vo]);
        d11 = longint'(vtx_cy[v2]) - longint'(vtx_cy[vo]);
        det = d00 * d11 - d01 * d10;
        pos = det > 0;
        if (!pos) begin
          for (int s = 0; s < 3; s++) vtx_flag[c[s]] = 1;
          n = (edges_searched < NUM_EDGE) ? edges_searched : NUM_EDGE;
          for (int e = 0; e < n; e++)
            if (edge_joins(e, c[0], c[1]) || edge_joins(e, c[1], c[2]) ||
                edge_joins(e, c[2], c[0]))
              edge_flag[e] = 1;
        end
        r.tri_tag = it.triangle_id;
        r.base_vertex = vo;
        r.first_column_vertex = v1;
        r.second_column_vertex = v2;
        r.m00 = d00[16:0]; r.m10 = d10[16:0]; r.m01 = d01[16:0]; r.m11 = d11[16:0];
        r.det_value = det[33:0];
        r.front_facing = pos;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // result checker
  initial begin
    mismatches = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        result_t got, exp_r;
        got.tri_tag = out_ch.tri_tag;
        got.base_vertex = out_ch.base_vertex;
        got.first_column_vertex = out_ch.first_column_vertex;
        got.second_column_vertex = out_ch.second_column_vertex;
        got.m00 = out_ch.m00; got.m10 = out_ch.m10;
        got.m01 = out_ch.m01; got.m11 = out_ch.m11;
        got.det_value = out_ch.det_value;
        got.front_facing = out_ch.front_facing;
        got.flag_value = out_ch.flag_value;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
          end
        end
      end
    end
  end

  // result-side stalls
  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ch.ready <= 1;
    end
  end

  task automatic write_edge_count(logic [11:0] v);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 2'(REG_EDGE_COUNT * 4); pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    edges_searched = 32'(v);
  endtask

  // valid stays high into the next item; callers drop it when the stream pauses
  task automatic send_item(item_t it, bit check_typed, result_t typed);
    result_t r;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.operation <= it.operation; in_ch.slot <= it.slot;
    in_ch.cur_x <= it.cur_x; in_ch.cur_y <= it.cur_y;
    in_ch.ref_x <= it.ref_x; in_ch.ref_y <= it.ref_y;
    in_ch.edge_end_a <= it.edge_end_a; in_ch.edge_end_b <= it.edge_end_b;
    in_ch.corner0 <= it.corner0; in_ch.corner1 <= it.corner1;
    in_ch.corner2 <= it.corner2; in_ch.triangle_id <= it.triangle_id;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_orientation(it, r)) begin
      if (check_typed && r !== typed) begin
        mismatches++;
        if (mismatches <= 10) $display("table row disagrees: typed %p, predicted %p", typed, r);
      end
      expected_results = {expected_results, r};
    end
    @(negedge clk);
  endtask

  // wait for quiet block before a register write; covers a full edge walk
  task automatic drain();
    in_ch.valid <= 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (NUM_EDGE + 64) @(negedge clk);
  endtask

  function automatic item_t rand_item();
    return item_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
  endfunction

  function automatic item_t vtx_item(int s, int cx, int cy, int rx, int ry);
    item_t it = '0;
    it.operation = OP_WR_VTX; it.slot = 11'(s);
    it.cur_x = 16'(cx); it.cur_y = 16'(cy); it.ref_x = 16'(rx); it.ref_y = 16'(ry);
    return it;
  endfunction

  function automatic item_t edge_item(int s, int a, int b);
    item_t it = '0;
    it.operation = OP_WR_EDGE; it.slot = 11'(s);
    it.edge_end_a = 10'(a); it.edge_end_b = 10'(b);
    return it;
  endfunction

  function automatic item_t tri_item(int a, int b, int c, int id);
    item_t it = '0;
    it.operation = OP_ANALYZE; it.corner0 = 10'(a); it.corner1 = 10'(b);
    it.corner2 = 10'(c);
    it.triangle_id = 16'(id);
    return it;
  endfunction

  function automatic item_t query_item(op_t op, int s);
    item_t it = '0;
    it.operation = op; it.slot = 11'(s);
    return it;
  endfunction

  function automatic item_t random_vertex_write(int nv);
    item_t it = '0;
    it = rand_item();
    it.operation = OP_WR_VTX;
    it.slot = ($urandom_range(0, 15) == 0) ? 11'($urandom_range(NUM_VTX, 2047))
                                           : 11'($urandom_range(0, nv - 1));
    if ($urandom_range(0, 3) == 0) begin
      it.cur_x = 16'($urandom_range(0, 31)) - 16'd16;
      it.cur_y = 16'($urandom_range(0, 31)) - 16'd16;
      it.ref_x = 16'($urandom_range(0, 7)); it.ref_y = 16'($urandom_range(0, 7));
    end
    return it;
  endfunction

  row_t dir_rows[$];
  int nv;

  initial begin
    item_t it;
    result_t none;
    row_t row;
    int pick;
    rst = 1;
    quiet_tail = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_ch.valid = 0;
    {in_ch.operation, in_ch.slot, in_ch.cur_x, in_ch.cur_y, in_ch.ref_x, in_ch.ref_y,
     in_ch.edge_end_a, in_ch.edge_end_b, in_ch.corner0, in_ch.corner1, in_ch.corner2,
     in_ch.triangle_id} = '0;
    edges_searched = 0;
    foreach (vtx_flag[i]) vtx_flag[i] = 0;
    foreach (edge_flag[i]) edge_flag[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    none = '0;

    write_edge_count(12'd4);
    // directed table
    row.has_exp = 0; row.exp_res = none;
    row.it = query_item(OP_Q_VTX, 0); row.has_exp = 1; row.exp_res = none;
    dir_rows = {dir_rows, row};
    row.it = query_item(OP_Q_EDGE, 2047); dir_rows = {dir_rows, row};
    row.it = query_item(OP_Q_VTX, 2047); dir_rows = {dir_rows, row};
    row.has_exp = 0;
    row.it = vtx_item(0, -32768, -32768, 0, 0); dir_rows = {dir_rows, row};
    row.it = vtx_item(1, 32767, -32768, 256, 0); dir_rows = {dir_rows, row};
    row.it = vtx_item(2, -32768, 32767, 0, 256); dir_rows = {dir_rows, row};
    row.it = vtx_item(3, 32767, 32767, -32768, 32767); dir_rows = {dir_rows, row};
    row.it = vtx_item(1023, 100, 100, 32767, -32768); dir_rows = {dir_rows, row};
    row.it = vtx_item(1500, 1, 1, 1, 1); dir_rows = {dir_rows, row};
    row.it = edge_item(0, 0, 1); dir_rows = {dir_rows, row};
    row.it = edge_item(1, 2, 1); dir_rows = {dir_rows, row};
    row.it = edge_item(2, 0, 3); dir_rows = {dir_rows, row};
    row.it = edge_item(3, 1023, 1023); dir_rows = {dir_rows, row};
    row.it = tri_item(0, 1, 2, 16'hFFFF); dir_rows = {dir_rows, row};
    row.it = tri_item(0, 2, 1, 0); dir_rows = {dir_rows, row};
    row.it = tri_item(3, 1023, 3, 16'h1234); dir_rows = {dir_rows, row};
    row.it = tri_item(3, 3, 3, 7); dir_rows = {dir_rows, row};
    row.it = query_item(OP_Q_VTX, 2); dir_rows = {dir_rows, row};
    row.it = query_item(OP_Q_EDGE, 1); dir_rows = {dir_rows, row};
    row.it = query_item(OP_Q_EDGE, 3); dir_rows = {dir_rows, row};
    row.it = '0; row.it.operation = 3'd6; dir_rows = {dir_rows, row};
    row.it.operation = 3'd7; dir_rows = {dir_rows, row};
    row.it = query_item(OP_CLEAR, 0); dir_rows = {dir_rows, row};
    row.it = query_item(OP_Q_VTX, 0); row.has_exp = 1; row.exp_res = none;
    dir_rows = {dir_rows, row};
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].has_exp, dir_rows[i].exp_res);

    // random phases with varying edge_count, empty and single-edge walks included
    nv = 16;
    for (int phase = 0; phase < 5; phase++) begin
      int limit_edges;
      drain();
      case (phase)
        0: write_edge_count(12'd0);
        1: write_edge_count(12'd1);
        default: write_edge_count(12'($urandom_range(1, 40)));
      endcase
      if (phase == 4) quiet_tail = 1;
      // fill every vertex the random part may reference
      for (int v = 0; v < nv; v++) begin
        it = random_vertex_write(nv); it.slot = 11'(v); send_item(it, 0, none);
      end
      limit_edges = (edges_searched < NUM_EDGE) ? edges_searched : NUM_EDGE;
      for (int e = 0; e < limit_edges; e++)
        if (!edge_written[e]) begin
          it = edge_item(e, $urandom_range(0, nv - 1), $urandom_range(0, nv - 1));
          if (e == 5) begin it.edge_end_a = 10'h3FF; it.edge_end_b = 10'h3FF; end
          send_item(it, 0, none);
        end
      for (int k = 0; k < RANDOM_ITEMS / 5; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          it = tri_item($urandom_range(0, nv - 1), $urandom_range(0, nv - 1),
                        $urandom_range(0, nv - 1), $urandom);
        end else if (pick < 55) it = random_vertex_write(nv);
        else if (pick < 65) begin
          it = rand_item();
          it.operation = OP_WR_EDGE;
          it.slot = 11'($urandom_range(0, 2047));
          if ($urandom_range(0, 1)) begin
            it.edge_end_a = 10'($urandom_range(0, nv - 1));
            it.edge_end_b = 10'($urandom_range(0, nv - 1));
          end
        end else if (pick < 78) begin
          it = rand_item();
          it.operation = OP_Q_VTX;
        end else if (pick < 92) begin
          it = rand_item();
          it.operation = OP_Q_EDGE;
        end else if (pick < 95) it = query_item(OP_CLEAR, $urandom_range(0, 2047));
        else begin
          it = rand_item();
          it.operation = 3'($urandom_range(6, 7));
        end
        // edge writes must not touch a searched slot with unseen ends; fine: always full
        send_item(it, 0, none);
      end
    end

    in_ch.valid <= 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (NUM_EDGE + 64) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
